>>> hdl/client_link_reassembly_credit_engine_assert.svh
// Assertion macros shared by the client link engine modules
`ifndef CLIENT_LINK_REASSEMBLY_CREDIT_ENGINE_ASSERT_SVH
`define CLIENT_LINK_REASSEMBLY_CREDIT_ENGINE_ASSERT_SVH

// same-cycle implication
`define CLRCE_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion %m failed");

// next-cycle implication
`define CLRCE_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion %m failed");

`endif

>>> hdl/clrce_pkg.sv
// Package: types, codes and constants of the client link engine
package clrce_pkg;

    localparam int DEF_MAX_CLIENTS = 16;
    localparam int FRAG_BYTES      = 124;
    localparam int MAX_MSG_BYTES   = 4096;

    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE  = 1'd1;
    localparam logic [LEN_W-1:0]     MAX_MESSAGE_RESET = 13'd4096;

    // request codes
    localparam logic [2:0] REQ_CONNECT    = 3'd0;
    localparam logic [2:0] REQ_DISCONNECT = 3'd1;
    localparam logic [2:0] REQ_CREDIT     = 3'd2;
    localparam logic [2:0] REQ_FRAGMENT   = 3'd3;
    localparam logic [2:0] REQ_SEND       = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_CONN_REPLY = 3'd0;
    localparam logic [2:0] KIND_DISC_REPLY = 3'd1;
    localparam logic [2:0] KIND_CREDIT     = 3'd2;
    localparam logic [2:0] KIND_FRAG_OUT   = 3'd3;
    localparam logic [2:0] KIND_DELIVERED  = 3'd4;
    localparam logic [2:0] KIND_SEND_ERR   = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_EXISTS     = 3'd2;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
    localparam logic [2:0] ST_TOO_BIG    = 3'd4;
    localparam logic [2:0] ST_NO_CREDIT  = 3'd5;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [7:0]       client_addr;
        logic [7:0]       peer_addr;
        logic [8:0]       frag_length;
        logic             frag_final;
        logic [LEN_W-1:0] send_bytes;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       out_client_addr;
        logic [7:0]       out_peer_addr;
        logic [2:0]       status;
        logic [LEN_W-1:0] out_length;
        logic             complete_flag;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic             connected;
        logic [7:0]       bound_peer;
        logic [7:0]       send_credits;
        logic [LEN_W-1:0] rx_collected;
        logic             rx_discarding;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FIRST,
        S_SECOND,
        S_FRAG
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_a;
        logic load_b;
        logic frag_step;
    } cmd_t;

    typedef struct packed {
        logic plan_first;
        logic plan_frag;
        logic second_pending;
        logic frag_last;
        logic out_free;
    } sts_t;

endpackage

>>> hdl/client_link_reassembly_credit_engine.sv
// Top level: client link reassembly and credit engine
//
// Usage:
//  - in_valid/in_stall/in_data carry one request per transfer (connect,
//    disconnect, host credit, received fragment, send). in_stall is high
//    while a request is in work; the block handles one request at a time.
//  - out_valid/out_stall/out_data carry results; last marks the final result
//    of a request. A stalled result holds in the output register until taken.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write client_count (index 0) and
//    max_message_bytes (index 1); cfg_ready is always high. Write only idle.
// Sequence: a request is captured in S_IDLE and decoded with a table
//  read-modify-write in S_EXEC; each result is then loaded into the output
//  register from S_FIRST, S_SECOND or S_FRAG, waiting while the output is
//  stalled. A request with no result returns to S_IDLE from S_EXEC; a send
//  gives one fragment per cycle while the receiver does not stall.
// Reset: clears all connections, credits and reassembly state at once (per
//  entry valid bits), client_count to 0 and max_message_bytes to 4096.
module client_link_reassembly_credit_engine
    import clrce_pkg::*;
#(
    parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    clrce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    clrce_dp #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> hdl/clrce_dp.sv
// Datapath: client table memory, config registers, request decode and output register
`include "client_link_reassembly_credit_engine_assert.svh"

module clrce_dp
    import clrce_pkg::*;
#(
    parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              in_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output out_item_t             out_data,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

    logic [4:0]        client_count_reg;
    logic [LEN_W-1:0]  max_msg_reg;

    in_item_t          in_reg;
    logic              ok_reg;
    logic [IDX_W-1:0]  idx_reg;

    entry_t            tbl_mem [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0] vld_reg;
    entry_t            rd_data_reg;
    logic              rd_vld_reg;

    out_item_t         a_reg, b_reg;
    logic              b_en_reg;
    logic [LEN_W-1:0]  left_reg;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [7:0]        lim8;
    logic              ok_in;
    logic [IDX_W-1:0]  rd_idx;
    logic [LEN_W:0]    lim_wide;
    logic [LEN_W-1:0]  limit;

    entry_t            e, ne;
    out_item_t         a, b;
    logic              a_en, b_en, f_en;
    logic [LEN_W:0]    sum;
    logic              disc1;
    logic [LEN_W-1:0]  coll1;

    logic [LEN_W-1:0]  part;
    logic              frag_last;

    // address check against the active client count
    always_comb
    begin
        lim8   = (32'(client_count_reg) > MAX_CLIENTS) ? 8'(MAX_CLIENTS)
                                                       : {3'b000, client_count_reg};
        ok_in  = (in_data.client_addr != 8'd0) && (in_data.client_addr <= lim8);
        rd_idx = ok_in ? IDX_W'(in_data.client_addr - 8'd1) : '0;
    end

    always_comb
    begin
        lim_wide = ({1'b0, max_msg_reg} > (LEN_W+1)'(MAX_MSG_BYTES))
                   ? (LEN_W+1)'(MAX_MSG_BYTES) : {1'b0, max_msg_reg};
        limit = lim_wide[LEN_W-1:0];
    end

    // request decode on the entry read back from the table
    always_comb
    begin
        e     = rd_vld_reg ? rd_data_reg : '0;
        ne    = e;
        a     = '0;
        b     = '0;
        a_en  = 1'b0;
        b_en  = 1'b0;
        f_en  = 1'b0;
        a.out_client_addr = in_reg.client_addr;
        a.out_peer_addr   = in_reg.peer_addr;
        b.out_client_addr = in_reg.client_addr;
        b.kind            = KIND_CREDIT;
        b.out_peer_addr   = e.bound_peer;
        sum   = {1'b0, e.rx_collected} + (LEN_W+1)'(in_reg.frag_length);
        disc1 = e.rx_discarding | (sum > {1'b0, limit});
        coll1 = disc1 ? e.rx_collected : sum[LEN_W-1:0];

        case (in_reg.req_type)
            REQ_CONNECT:
            begin
                a.kind = KIND_CONN_REPLY;
                a_en   = 1'b1;
                if (!ok_reg)
                begin
                    a.status = ST_NOT_FOUND;
                end
                else
                begin
                    if (e.connected)
                    begin
                        a.status = ST_EXISTS;
                    end
                    else
                    begin
                        ne.connected  = 1'b1;
                        ne.bound_peer = in_reg.peer_addr;
                    end
                    b_en            = 1'b1;
                    b.out_peer_addr = ne.bound_peer;
                end
            end
            REQ_DISCONNECT:
            begin
                a.kind = KIND_DISC_REPLY;
                a_en   = 1'b1;
                if (ok_reg && e.connected)
                    ne.connected = 1'b0;
                else
                    a.status = ST_NOT_FOUND;
            end
            REQ_CREDIT:
            begin
                if (ok_reg && e.connected && (e.send_credits != 8'hFF))
                    ne.send_credits = e.send_credits + 8'd1;
            end
            REQ_FRAGMENT:
            begin
                if (ok_reg && e.connected && (e.bound_peer == in_reg.peer_addr))
                begin
                    if (in_reg.frag_final)
                    begin
                        ne.rx_collected  = '0;
                        ne.rx_discarding = 1'b0;
                        a_en = 1'b1;
                        if (!disc1)
                        begin
                            a.kind       = KIND_DELIVERED;
                            a.out_length = coll1;
                            b_en         = 1'b1;
                        end
                        else
                        begin
                            a = b;
                        end
                    end
                    else
                    begin
                        ne.rx_collected  = coll1;
                        ne.rx_discarding = disc1;
                    end
                end
            end
            REQ_SEND:
            begin
                a.kind          = KIND_SEND_ERR;
                a.out_peer_addr = 8'd0;
                if (!ok_reg)
                begin
                    a_en     = 1'b1;
                    a.status = ST_BAD_HANDLE;
                end
                else if (in_reg.send_bytes > limit)
                begin
                    a_en     = 1'b1;
                    a.status = ST_TOO_BIG;
                end
                else if (!e.connected || (e.send_credits == 8'd0))
                begin
                    a_en     = 1'b1;
                    a.status = ST_NO_CREDIT;
                end
                else
                begin
                    ne.send_credits = e.send_credits - 8'd1;
                    f_en            = (in_reg.send_bytes != '0);
                    a.kind          = KIND_FRAG_OUT;
                    a.out_peer_addr = e.bound_peer;
                end
            end
            default:
            begin
            end
        endcase
    end

    // fragment splitter, one fragment per step
    always_comb
    begin
        frag_last = (left_reg <= LEN_W'(FRAG_BYTES));
        part      = frag_last ? left_reg : LEN_W'(FRAG_BYTES);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (cmd.load_a)
        begin
            out_valid_next     = 1'b1;
            out_data_next      = a_reg;
            out_data_next.last = !b_en_reg;
        end
        else if (cmd.load_b)
        begin
            out_valid_next     = 1'b1;
            out_data_next      = b_reg;
            out_data_next.last = 1'b1;
        end
        else if (cmd.frag_step)
        begin
            out_valid_next              = 1'b1;
            out_data_next               = a_reg;
            out_data_next.out_length    = part;
            out_data_next.complete_flag = frag_last;
            out_data_next.last          = frag_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_count_reg <= '0;
            max_msg_reg      <= MAX_MESSAGE_RESET;
            ok_reg           <= 1'b0;
            vld_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            b_en_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_CLIENT_COUNT))
                client_count_reg <= cfg_data[4:0];
            if (cfg_valid && (cfg_index == CFG_MAX_MESSAGE))
                max_msg_reg <= cfg_data[LEN_W-1:0];
            if (cmd.capture)
            begin
                ok_reg     <= ok_in;
                rd_vld_reg <= vld_reg[rd_idx];
            end
            if (cmd.exec)
            begin
                vld_reg[idx_reg] <= 1'b1;
                b_en_reg         <= b_en;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg      <= in_data;
            idx_reg     <= rd_idx;
            rd_data_reg <= tbl_mem[rd_idx];
        end
        if (cmd.exec)
        begin
            tbl_mem[idx_reg] <= ne;
            a_reg            <= a;
            b_reg            <= b;
            left_reg         <= in_reg.send_bytes;
        end
        else if (cmd.frag_step)
        begin
            left_reg <= left_reg - part;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.plan_first     = a_en;
    assign sts.plan_frag      = f_en;
    assign sts.second_pending = b_en_reg;
    assign sts.frag_last      = frag_last;
    assign sts.out_free       = !out_valid_reg || !out_stall;

    `CLRCE_ASSERT_IMP(a_frag_nonzero, clk, rst_n, cmd.frag_step, left_reg != '0)
    `CLRCE_ASSERT_IMP(a_second_planned, clk, rst_n, cmd.load_b, b_en_reg)
    `CLRCE_ASSERT_IMP(a_idx_range, clk, rst_n, ok_reg, 32'(idx_reg) < MAX_CLIENTS)

endmodule

>>> hdl/clrce_ctrl.sv
// Controller: request sequencing and result issue
`include "client_link_reassembly_credit_engine_assert.svh"

module clrce_ctrl
    import clrce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.plan_first)
                    state_next = S_FIRST;
                else if (sts.plan_frag)
                    state_next = S_FRAG;
                else
                    state_next = S_IDLE;
            end
            S_FIRST:
            begin
                if (sts.out_free)
                begin
                    cmd.load_a = 1'b1;
                    state_next = sts.second_pending ? S_SECOND : S_IDLE;
                end
            end
            S_SECOND:
            begin
                if (sts.out_free)
                begin
                    cmd.load_b = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FRAG:
            begin
                if (sts.out_free)
                begin
                    cmd.frag_step = 1'b1;
                    if (sts.frag_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CLRCE_ASSERT_NXT(a_accept_exec, clk, rst_n, in_valid && !in_stall, state_reg == S_EXEC)
    `CLRCE_ASSERT_IMP(a_one_load, clk, rst_n, 1'b1, $onehot0({cmd.load_a, cmd.load_b, cmd.frag_step}))
    `CLRCE_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_a || cmd.load_b || cmd.frag_step, sts.out_free)

endmodule

>>> verif/client_link_reassembly_credit_engine_test.sv
// Testbench: client link engine run through directed and random requests against a predictor
`timescale 1ns / 100ps

import clrce_pkg::*;

class link_ledger;
    bit          connected    [DEF_MAX_CLIENTS];
    logic [7:0]  bound_peer   [DEF_MAX_CLIENTS];
    logic [7:0]  send_credits [DEF_MAX_CLIENTS];
    int unsigned rx_collected [DEF_MAX_CLIENTS];
    bit          rx_discarding[DEF_MAX_CLIENTS];
    int unsigned client_count;
    int unsigned max_message;
    out_item_t   owed_results[$];
    out_item_t   fresh[$];
    int          errors;

    function void clear_table();
        for (int k = 0; k < DEF_MAX_CLIENTS; k++)
        begin
            connected[k]     = 1'b0;
            bound_peer[k]    = '0;
            send_credits[k]  = '0;
            rx_collected[k]  = 0;
            rx_discarding[k] = 1'b0;
        end
        client_count = 0;
        max_message  = 32'(MAX_MESSAGE_RESET);
        owed_results.delete();
        errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        if (index == CFG_CLIENT_COUNT)
            client_count = 32'(value[4:0]);
        else if (index == CFG_MAX_MESSAGE)
            max_message = 32'(value);
    endfunction

    function int unsigned msg_limit();
        return (max_message > MAX_MSG_BYTES) ? MAX_MSG_BYTES : max_message;
    endfunction

    function void add(logic [2:0] kind, logic [7:0] ca, logic [7:0] pa, logic [2:0] status,
                      int unsigned len, bit complete);
        out_item_t r;
        r.kind            = kind;
        r.out_client_addr = ca;
        r.out_peer_addr   = pa;
        r.status          = status;
        r.out_length      = LEN_W'(len);
        r.complete_flag   = complete;
        r.last            = 1'b0;
        fresh.push_back(r);
    endfunction

    function void note_request(in_item_t req);
        bit          ok;
        int unsigned span;
        int unsigned slot;
        int unsigned left;
        int unsigned part;
        out_item_t   r;
        span = (client_count > DEF_MAX_CLIENTS) ? DEF_MAX_CLIENTS : client_count;
        ok   = (req.client_addr >= 1) && (req.client_addr <= span);
        slot = ok ? 32'(req.client_addr) - 1 : 0;
        fresh.delete();
        case (req.req_type)
            REQ_CONNECT:
            begin
                if (!ok)
                    add(KIND_CONN_REPLY, req.client_addr, req.peer_addr, ST_NOT_FOUND, 0, 1'b0);
                else
                begin
                    if (connected[slot])
                        add(KIND_CONN_REPLY, req.client_addr, req.peer_addr, ST_EXISTS, 0,
                            1'b0);
                    else
                    begin
                        connected[slot]  = 1'b1;
                        bound_peer[slot] = req.peer_addr;
                        add(KIND_CONN_REPLY, req.client_addr, req.peer_addr, ST_OK, 0, 1'b0);
                    end
                    add(KIND_CREDIT, req.client_addr, bound_peer[slot], ST_OK, 0, 1'b0);
                end
            end
            REQ_DISCONNECT:
            begin
                if (!ok || !connected[slot])
                    add(KIND_DISC_REPLY, req.client_addr, req.peer_addr, ST_NOT_FOUND, 0, 1'b0);
                else
                begin
                    connected[slot] = 1'b0;
                    add(KIND_DISC_REPLY, req.client_addr, req.peer_addr, ST_OK, 0, 1'b0);
                end
            end
            REQ_CREDIT:
            begin
                if (ok && connected[slot] && send_credits[slot] != 8'hFF)
                    send_credits[slot] = send_credits[slot] + 8'd1;
            end
            REQ_FRAGMENT:
            begin
                if (ok && connected[slot] && bound_peer[slot] == req.peer_addr)
                begin
                    if (!rx_discarding[slot] &&
                        rx_collected[slot] + 32'(req.frag_length) > msg_limit())
                        rx_discarding[slot] = 1'b1;
                    if (!rx_discarding[slot])
                        rx_collected[slot] = rx_collected[slot] + 32'(req.frag_length);
                    if (req.frag_final)
                    begin
                        if (!rx_discarding[slot])
                            add(KIND_DELIVERED, req.client_addr, req.peer_addr, ST_OK,
                                rx_collected[slot], 1'b0);
                        rx_collected[slot]  = 0;
                        rx_discarding[slot] = 1'b0;
                        add(KIND_CREDIT, req.client_addr, bound_peer[slot], ST_OK, 0, 1'b0);
                    end
                end
            end
            REQ_SEND:
            begin
                if (!ok)
                    add(KIND_SEND_ERR, req.client_addr, 8'd0, ST_BAD_HANDLE, 0, 1'b0);
                else if (req.send_bytes > msg_limit())
                    add(KIND_SEND_ERR, req.client_addr, 8'd0, ST_TOO_BIG, 0, 1'b0);
                else if (!connected[slot] || send_credits[slot] == 0)
                    add(KIND_SEND_ERR, req.client_addr, 8'd0, ST_NO_CREDIT, 0, 1'b0);
                else
                begin
                    left = 32'(req.send_bytes);
                    while (left != 0)
                    begin
                        part = (left > FRAG_BYTES) ? FRAG_BYTES : left;
                        left = left - part;
                        add(KIND_FRAG_OUT, req.client_addr, bound_peer[slot], ST_OK, part,
                            left == 0);
                    end
                    send_credits[slot] = send_credits[slot] - 8'd1;
                end
            end
            default:
            begin
            end
        endcase
        foreach (fresh[k])
        begin
            r      = fresh[k];
            r.last = (k == fresh.size() - 1);
            owed_results.push_back(r);
        end
    endfunction

    function void compare(string field, logic [12:0] want, logic [12:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (owed_results.size() == 0)
        begin
            $display("%0t: unexpected result kind %0d client %0d", $time, got.kind,
                     got.out_client_addr);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        compare("kind", 13'(want.kind), 13'(got.kind));
        compare("out_client_addr", 13'(want.out_client_addr), 13'(got.out_client_addr));
        compare("out_peer_addr", 13'(want.out_peer_addr), 13'(got.out_peer_addr));
        compare("status", 13'(want.status), 13'(got.status));
        compare("out_length", want.out_length, got.out_length);
        compare("complete_flag", 13'(want.complete_flag), 13'(got.complete_flag));
        compare("last", 13'(want.last), 13'(got.last));
    endfunction
endclass

module client_link_reassembly_credit_engine_test;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] REQ_RESERVED   = 3'd7;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    in_item_t              in_data    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          active_clients     = 0;
    int unsigned msg_cap            = MAX_MSG_BYTES;
    int          quiet_cycles       = 0;
    logic [7:0]  home_peer [256];
    link_ledger  ledger             = new();

    client_link_reassembly_credit_engine u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                ledger.write_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                ledger.note_request(in_data);
            if (out_valid && !out_stall)
                ledger.check_result(out_data);
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] count_word, logic [CFG_DATA_W-1:0] max_word);
        set_register(CFG_CLIENT_COUNT, count_word);
        set_register(CFG_MAX_MESSAGE, max_word);
        active_clients = (count_word[4:0] > DEF_MAX_CLIENTS) ? DEF_MAX_CLIENTS : count_word[4:0];
        msg_cap        = (max_word > MAX_MSG_BYTES) ? MAX_MSG_BYTES : max_word;
    endtask

    task automatic issue(logic [2:0] req, logic [7:0] ca, logic [7:0] pa, logic [8:0] flen,
                         logic fin, logic [LEN_W-1:0] nbytes);
        in_item_t item;
        item.req_type    = req;
        item.client_addr = ca;
        item.peer_addr   = pa;
        item.frag_length = flen;
        item.frag_final  = fin;
        item.send_bytes  = nbytes;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
    endtask

    // hold off new requests until every owed result is out and the engine has gone idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int items, int sender_pct, int receiver_pct);
        logic [2:0]       req;
        logic [7:0]       ca;
        logic [7:0]       pa;
        logic [8:0]       flen;
        logic             fin;
        logic [LEN_W-1:0] nbytes;
        int               pick;
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        repeat (items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8 && active_clients > 0)
                ca = 8'($urandom_range(1, active_clients));
            else if (pick < 9)
                ca = ($urandom_range(0, 1) != 0) ? 8'(active_clients + 1) : 8'd0;
            else
                ca = 8'($urandom_range(0, 255));
            pa     = home_peer[ca];
            flen   = 9'($urandom_range(0, 150));
            fin    = ($urandom_range(0, 99) < 35);
            nbytes = LEN_W'($urandom_range(0, 260));
            pick   = $urandom_range(0, 99);
            if (pick < 10)
            begin
                req = REQ_CONNECT;
                if ($urandom_range(0, 9) == 0)
                    pa = 8'($urandom_range(0, 255));
            end
            else if (pick < 16)
            begin
                req = REQ_DISCONNECT;
                pa  = 8'($urandom_range(0, 255));
            end
            else if (pick < 40)
            begin
                req = REQ_CREDIT;
                pa  = 8'($urandom_range(0, 255));
            end
            else if (pick < 70)
            begin
                req = REQ_FRAGMENT;
                if ($urandom_range(0, 9) == 0)
                    pa = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    flen = 9'($urandom_range(0, 511));
            end
            else if (pick < 93)
            begin
                req  = REQ_SEND;
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    nbytes = LEN_W'($urandom_range(0, msg_cap));
                else if (pick < 32)
                    nbytes = LEN_W'($urandom_range(0, 8191));
            end
            else
            begin
                // noise: every field at random, reserved request codes included
                req    = 3'($urandom_range(0, 7));
                ca     = 8'($urandom_range(0, 255));
                pa     = 8'($urandom_range(0, 255));
                flen   = 9'($urandom_range(0, 511));
                nbytes = LEN_W'($urandom_range(0, 8191));
            end
            issue(req, ca, pa, flen, fin, nbytes);
            if ($urandom_range(0, 99) < 3)
                drain();
        end
    endtask

    initial
    begin
        ledger.clear_table();
        foreach (home_peer[k])
            home_peer[k] = 8'($urandom_range(0, 255));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // client_count is 0 out of reset: no address is valid
        issue(REQ_CONNECT, 8'd1, 8'd9, 9'd0, 1'b0, 13'd0);
        issue(REQ_SEND, 8'd1, 8'd0, 9'd0, 1'b0, 13'd5);
        drain();

        configure(13'd16, 13'd300);
        issue(REQ_CONNECT, 8'd1, 8'hFF, 9'd0, 1'b0, 13'd0);
        issue(REQ_CONNECT, 8'd1, 8'h05, 9'd0, 1'b0, 13'd0);
        issue(REQ_CONNECT, 8'd16, 8'h00, 9'd0, 1'b0, 13'd0);
        issue(REQ_CONNECT, 8'd17, 8'h33, 9'd0, 1'b0, 13'd0);
        issue(REQ_CONNECT, 8'd0, 8'hAA, 9'd0, 1'b0, 13'd0);
        issue(REQ_CREDIT, 8'd1, 8'h77, 9'd0, 1'b0, 13'd0);
        issue(REQ_CREDIT, 8'd1, 8'h00, 9'd0, 1'b0, 13'd0);
        issue(REQ_SEND, 8'd1, 8'h00, 9'd0, 1'b0, 13'd0);
        issue(REQ_SEND, 8'd1, 8'h00, 9'd0, 1'b0, 13'd250);
        issue(REQ_SEND, 8'd1, 8'h00, 9'd0, 1'b0, 13'd1);
        issue(REQ_SEND, 8'd1, 8'h00, 9'd0, 1'b0, 13'd301);
        issue(REQ_SEND, 8'd0, 8'h00, 9'd0, 1'b0, 13'd10);
        issue(REQ_SEND, 8'd2, 8'h00, 9'd0, 1'b0, 13'd10);
        issue(REQ_FRAGMENT, 8'd1, 8'hFF, 9'd200, 1'b0, 13'd0);
        issue(REQ_FRAGMENT, 8'd1, 8'hFF, 9'd100, 1'b1, 13'd0);
        issue(REQ_FRAGMENT, 8'd1, 8'hFF, 9'd511, 1'b0, 13'd0);
        issue(REQ_FRAGMENT, 8'd1, 8'hFF, 9'd0, 1'b1, 13'd0);
        issue(REQ_FRAGMENT, 8'd1, 8'h03, 9'd20, 1'b1, 13'd0);
        issue(REQ_FRAGMENT, 8'd2, 8'hFF, 9'd20, 1'b1, 13'd0);
        issue(REQ_CREDIT, 8'd2, 8'h00, 9'd0, 1'b0, 13'd0);
        issue(REQ_DISCONNECT, 8'd1, 8'hFF, 9'd0, 1'b0, 13'd0);
        issue(REQ_DISCONNECT, 8'd1, 8'hFF, 9'd0, 1'b0, 13'd0);
        issue(REQ_DISCONNECT, 8'd200, 8'h12, 9'd0, 1'b0, 13'd0);
        issue(REQ_RESERVED, 8'd1, 8'hFF, 9'd1, 1'b1, 13'd1);
        drain();

        // 256 credits on an empty counter: a wrapping count would refuse the send
        repeat (256)
            issue(REQ_CREDIT, 8'd16, 8'h00, 9'd0, 1'b0, 13'd0);
        issue(REQ_SEND, 8'd16, 8'h00, 9'd0, 1'b0, 13'd124);
        drain();

        configure(13'd16, 13'd4096);
        run_phase(30, 0, 0);
        drain();
        configure(13'd5, 13'd1);
        run_phase(30, 49, 0);
        drain();
        // bits above the register width are dropped; both values then clamp
        configure(13'h1FFF, 13'h1FFF);
        run_phase(30, 0, 49);
        drain();
        configure(13'd1, 13'd700);
        run_phase(30, 19, 19);
        drain();
        configure(13'd0, 13'd124);
        run_phase(15, 0, 0);
        drain();
        configure(13'd12, 13'd4095);
        run_phase(30, 19, 19);
        drain();

        if (ledger.owed_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, ledger.owed_results.size());
        if (ledger.errors == 0 && ledger.owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
